>>> rtl/core/wik_pkg.sv
// Package: payload types, register map and fixed-point constants for the wheel kinematics block.
`timescale 1ns / 1ps
package wik_pkg;

	typedef struct packed {
		logic signed [15:0] cmd_vx;
		logic signed [15:0] cmd_vy;
		logic signed [15:0] cmd_vth;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] wheel0_speed;
		logic signed [31:0] wheel1_speed;
		logic signed [31:0] wheel2_speed;
		logic signed [31:0] wheel3_speed;
		logic               mode_error;
	} res_t;

	typedef enum logic [2:0] {
		REG_WHEEL_MODE    = 3'd0,
		REG_MAX_VX        = 3'd1,
		REG_MAX_VY        = 3'd2,
		REG_MAX_VTH       = 3'd3,
		REG_TYRE_RAD      = 3'd4,
		REG_WHEEL_SPACING = 3'd5,
		REG_BODY_WIDTH    = 3'd6,
		REG_BODY_LENGTH   = 3'd7
	} reg_idx_t;

	localparam logic [2:0] MODE_DIFF  = 3'd2;
	localparam logic [2:0] MODE_OMNI3 = 3'd3;
	localparam logic [2:0] MODE_OMNI4 = 3'd4;

	// 3/pi and 3*sqrt(3)/pi in Q30
	localparam logic signed [31:0] K_INV_PI3 = 32'sd1025347913;
	localparam logic signed [31:0] K_SQ3_PI3 = 32'sd1775953681;

	localparam int NWHEEL   = 4;
	localparam int DIV_BITS = 4;                    // quotient bits per divider stage
	localparam int DIV_ST   = 9;                    // divider stages
	localparam int QW       = DIV_BITS * DIV_ST;    // quotient / dividend width
	localparam int PRE_ST   = 5;                    // stages before the divider
	localparam int NST      = PRE_ST + DIV_ST + 1;  // total stages incl. output

endpackage

>>> rtl/core/wheel_inverse_kinematics.sv
// Top level: pipelined clamp, wheel mixing and divide-by-radius for body velocity commands.
`timescale 1ns / 1ps
// Channel  Dir  Handshake            Payload
// cmd      in   cmd_valid/cmd_stall  wik_pkg::cmd_t  (vx, vy, vth)
// res      out  res_valid/res_stall  wik_pkg::res_t  (four wheel speeds, mode error)
// cfg      in   cfg_valid/cfg_ready  cfg_index (3 b), cfg_data (16 b)
//
// Fifteen register stages; one transaction can enter every cycle unless res_stall has
// backed the pipe up to cmd. Five stages clamp, mix and scale, nine restoring divider
// stages (four quotient bits each) divide by the radius, one register saturates.
// Each stage holds unless the one after it is empty or moving, so a stall on res fills
// bubbles before it reaches cmd; nothing is dropped or repeated.
// Reset (arst_n low) empties the pipe and loads the register defaults.
module wheel_inverse_kinematics (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  wik_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output wik_pkg::res_t  res,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [15:0]    cfg_data
);
	import wik_pkg::*;

	// configuration registers
	logic [2:0]  wheel_mode_q;
	logic [14:0] max_vx_q, max_vy_q, max_vth_q;
	logic [15:0] tyre_rad_q, wheel_spacing_q, body_width_q, body_length_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_mode_q    <= 3'd4;
			max_vx_q        <= 15'd1000;
			max_vy_q        <= 15'd1000;
			max_vth_q       <= 15'd2000;
			tyre_rad_q      <= 16'd500;
			wheel_spacing_q <= 16'd3000;
			body_width_q    <= 16'd2000;
			body_length_q   <= 16'd2000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WHEEL_MODE:    wheel_mode_q    <= cfg_data[2:0];
				REG_MAX_VX:        max_vx_q        <= cfg_data[14:0];
				REG_MAX_VY:        max_vy_q        <= cfg_data[14:0];
				REG_MAX_VTH:       max_vth_q       <= cfg_data[14:0];
				REG_TYRE_RAD:      tyre_rad_q      <= cfg_data;
				REG_WHEEL_SPACING: wheel_spacing_q <= cfg_data;
				REG_BODY_WIDTH:    body_width_q    <= cfg_data;
				REG_BODY_LENGTH:   body_length_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow: a stage loads when it is empty or its successor loads
	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = !v_q[NST-1] || !res_stall;
		for (int k = NST-2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign cmd_stall = !en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= cmd_valid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	// clamp helper
	function automatic logic signed [16:0] clamp(input logic signed [15:0] x,
	                                             input logic [14:0] lim);
		logic signed [16:0] l, xs;
		l  = $signed({2'b00, lim});
		xs = 17'(x);
		if (xs > l)       clamp = l;
		else if (xs < -l) clamp = -l;
		else              clamp = xs;
	endfunction

	// s1: clamped command
	logic signed [16:0] vx_s1, vy_s1, vth_s1;
	logic [2:0]         mode_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			vx_s1   <= clamp(cmd.cmd_vx,  max_vx_q);
			vy_s1   <= clamp(cmd.cmd_vy,  max_vy_q);
			vth_s1  <= clamp(cmd.cmd_vth, max_vth_q);
			mode_s1 <= wheel_mode_q;
		end
	end

	// s2: partial terms
	logic signed [35:0] vx10k_s2, vx20k_s2, vy10k_s2, vy20k_s2;
	logic signed [35:0] vxpy20k_s2, vxmy20k_s2, vths_s2, t4_s2;
	logic [2:0]         mode_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			vx10k_s2   <= 36'(vx_s1) * 36'sd10000;
			vx20k_s2   <= 36'(vx_s1) * 36'sd20000;
			vy10k_s2   <= 36'(vy_s1) * 36'sd10000;
			vy20k_s2   <= 36'(vy_s1) * 36'sd20000;
			vxpy20k_s2 <= (36'(vx_s1) + 36'(vy_s1)) * 36'sd20000;
			vxmy20k_s2 <= (36'(vx_s1) - 36'(vy_s1)) * 36'sd20000;
			vths_s2    <= 36'(vth_s1) * $signed({20'd0, wheel_spacing_q});
			t4_s2      <= 36'(vth_s1) *
			              $signed(36'({1'b0, body_width_q} + {1'b0, body_length_q}));
			mode_s2    <= mode_s1;
		end
	end

	// s3: per-wheel numerators before the constant
	logic signed [35:0] p_s3 [NWHEEL];
	logic signed [35:0] a_s3;
	logic               err_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < NWHEEL; i++) p_s3[i] <= '0;
			a_s3   <= '0;
			err_s3 <= 1'b0;
			unique case (mode_s2)
				MODE_DIFF: begin
					p_s3[0] <= vths_s2 - vx20k_s2;
					p_s3[1] <= vx20k_s2 + vths_s2;
				end
				MODE_OMNI3: begin
					p_s3[0] <= vy10k_s2 + (vths_s2 <<< 1);
					p_s3[1] <= vy10k_s2 + (vths_s2 <<< 1);
					p_s3[2] <= (vths_s2 <<< 1) - vy20k_s2;
					a_s3    <= vx10k_s2;
				end
				MODE_OMNI4: begin
					p_s3[0] <= vxpy20k_s2 + t4_s2;
					p_s3[1] <= t4_s2 - vxmy20k_s2;
					p_s3[2] <= t4_s2 - vxpy20k_s2;
					p_s3[3] <= vxmy20k_s2 + t4_s2;
				end
				default: err_s3 <= 1'b1;
			endcase
		end
	end

	// s4: scale by the Q30 constants
	logic signed [63:0] pk_s4 [NWHEEL];
	logic signed [63:0] aks_s4;
	logic               err_s4;
	logic signed [67:0] prod [NWHEEL];
	logic signed [67:0] aprod;

	always_comb begin
		for (int i = 0; i < NWHEEL; i++) prod[i] = 68'(p_s3[i]) * 68'(K_INV_PI3);
		aprod = 68'(a_s3) * 68'(K_SQ3_PI3);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < NWHEEL; i++) pk_s4[i] <= prod[i][63:0];
			aks_s4 <= aprod[63:0];
			err_s4 <= err_s3;
		end
	end

	// s5: final numerator, sign and magnitude; divide by 2^31 is a shift
	logic signed [63:0] w [NWHEEL];
	logic [63:0]        mag [NWHEEL];
	logic [QW-1:0]      dq_s5 [NWHEEL];
	logic [NWHEEL-1:0]  neg_s5, zero_s5;
	logic               err_s5;

	always_comb begin
		w[0] = pk_s4[0] + aks_s4;
		w[1] = pk_s4[1] - aks_s4;
		w[2] = pk_s4[2];
		w[3] = pk_s4[3];
		for (int i = 0; i < NWHEEL; i++) mag[i] = w[i][63] ? 64'(-w[i]) : 64'(w[i]);
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < NWHEEL; i++) begin
				dq_s5[i]   <= QW'(mag[i][63:31]);
				neg_s5[i]  <= w[i][63];
				zero_s5[i] <= (mag[i] == 64'd0);
			end
			err_s5 <= err_s4;
		end
	end

	// divider stages: dividend bits leave dq at the top, quotient bits enter at the bottom
	logic [QW-1:0]     dq_d  [DIV_ST][NWHEEL];
	logic [15:0]       rem_d [DIV_ST][NWHEEL];
	logic [NWHEEL-1:0] neg_d [DIV_ST];
	logic [NWHEEL-1:0] zero_d[DIV_ST];
	logic              err_d [DIV_ST];

	logic [QW-1:0] dq_n  [DIV_ST][NWHEEL];
	logic [15:0]   rem_n [DIV_ST][NWHEEL];

	always_comb begin
		logic [16:0]   r17;
		logic [QW-1:0] dq;
		logic [15:0]   rm;
		for (int s = 0; s < DIV_ST; s++) begin
			for (int i = 0; i < NWHEEL; i++) begin
				dq = (s == 0) ? dq_s5[i] : dq_d[(s == 0) ? 0 : s-1][i];
				rm = (s == 0) ? 16'd0    : rem_d[(s == 0) ? 0 : s-1][i];
				for (int b = 0; b < DIV_BITS; b++) begin
					r17 = {rm, dq[QW-1]};
					dq  = {dq[QW-2:0], 1'b0};
					if (r17 >= {1'b0, tyre_rad_q}) begin
						r17   = r17 - {1'b0, tyre_rad_q};
						dq[0] = 1'b1;
					end
					rm = r17[15:0];
				end
				dq_n[s][i]  = dq;
				rem_n[s][i] = rm;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < DIV_ST; s++) begin
			if (en[PRE_ST+s]) begin
				for (int i = 0; i < NWHEEL; i++) begin
					dq_d[s][i]  <= dq_n[s][i];
					rem_d[s][i] <= rem_n[s][i];
				end
				neg_d[s]  <= (s == 0) ? neg_s5  : neg_d[(s == 0) ? 0 : s-1];
				zero_d[s] <= (s == 0) ? zero_s5 : zero_d[(s == 0) ? 0 : s-1];
				err_d[s]  <= (s == 0) ? err_s5  : err_d[(s == 0) ? 0 : s-1];
			end
		end
	end

	// output stage: saturate and apply sign
	function automatic logic [31:0] sat(input logic [QW-1:0] q, input logic neg,
	                                    input logic zero);
		if (zero)      sat = 32'd0;
		else if (neg)  sat = (q >= QW'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-q);
		else           sat = (q >  QW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
	endfunction

	res_t res_q;

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			res_q.wheel0_speed <= sat(dq_d[DIV_ST-1][0], neg_d[DIV_ST-1][0], zero_d[DIV_ST-1][0]);
			res_q.wheel1_speed <= sat(dq_d[DIV_ST-1][1], neg_d[DIV_ST-1][1], zero_d[DIV_ST-1][1]);
			res_q.wheel2_speed <= sat(dq_d[DIV_ST-1][2], neg_d[DIV_ST-1][2], zero_d[DIV_ST-1][2]);
			res_q.wheel3_speed <= sat(dq_d[DIV_ST-1][3], neg_d[DIV_ST-1][3], zero_d[DIV_ST-1][3]);
			res_q.mode_error   <= err_d[DIV_ST-1];
		end
	end

	assign res       = res_q;
	assign res_valid = v_q[NST-1];

	// checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> v_q[0])
		else $error("accepted command did not enter stage 1");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.mode_error) |-> (res.wheel0_speed == 0 && res.wheel1_speed == 0
		&& res.wheel2_speed == 0 && res.wheel3_speed == 0))
		else $error("mode error with non-zero wheel speed");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall && v_q[NST-2]) |=> v_q[NST-2])
		else $error("stage before output lost its transaction under stall");

endmodule

>>> tb/wheel_inverse_kinematics_test.sv
// Testbench: random and directed velocity commands checked against a wheel speed predictor.
`timescale 1ns / 1ps
module wheel_inverse_kinematics_test;
	import wik_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	cmd_t        cmd;
	logic        res_valid;
	logic        res_stall;
	res_t        res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	wheel_inverse_kinematics u_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam int DRAIN_CYCLES = 40;     // comfortably past the pipeline latency
	localparam int STALL_LIMIT  = 20000;  // cycles with no transaction before giving up
	localparam int LONG_HOLD    = 300;    // receiver hold-off, well past the pipe depth

	cmd_t        cmd_pending[$];          // commands waiting to be offered
	res_t        speeds_due[$];           // predicted wheel speeds, oldest first
	logic [15:0] reg_copy[8];             // shadow of the register file
	int          err_count = 0;
	bit          quiet;                   // no idling on either side
	bit          hold_req;                // ask the receiver for one long hold-off
	bit          hold_done;               // the long hold-off has been taken
	int          send_idle;
	int          recv_idle;
	int          hold_cnt;
	int          dead_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction
	function automatic longint limit_cmd(logic signed [15:0] v, logic [15:0] lim);
		longint l;
		l = longint'(lim);
		if (longint'(v) > l) return l;
		if (longint'(v) < -l) return -l;
		return longint'(v);
	endfunction

	// num / (radius * 2^31), truncated toward zero, saturated to 32 bits
	function automatic logic signed [31:0] to_speed(longint num, logic [15:0] radius);
		longint unsigned mag;
		longint unsigned q;
		bit neg;
		neg = num < 0;
		mag = neg ? longint'(-num) : num;
		if (radius == 16'd0) begin
			if (mag == 0) return 32'sd0;
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		q = mag / (longint'(radius) << 31);
		if (neg) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			return 32'(-q);
		end
		if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
		return 32'(q);
	endfunction

	function automatic res_t wheel_speeds(cmd_t c);
		longint vx, vy, vth, sp, t4, a, b, k, ks;
		longint w[4];
		res_t r;
		vx  = limit_cmd(c.cmd_vx, reg_copy[REG_MAX_VX]);
		vy  = limit_cmd(c.cmd_vy, reg_copy[REG_MAX_VY]);
		vth = limit_cmd(c.cmd_vth, reg_copy[REG_MAX_VTH]);
		sp  = longint'(reg_copy[REG_WHEEL_SPACING]);
		t4  = vth * (longint'(reg_copy[REG_BODY_WIDTH]) + longint'(reg_copy[REG_BODY_LENGTH]));
		k   = longint'(K_INV_PI3);
		ks  = longint'(K_SQ3_PI3);
		foreach (w[i]) w[i] = 0;
		r = '0;
		case (reg_copy[REG_WHEEL_MODE][2:0])
			MODE_DIFF: begin
				w[0] = -(20000 * vx - vth * sp) * k;
				w[1] = (20000 * vx + vth * sp) * k;
			end
			MODE_OMNI3: begin
				a = 10000 * vx * ks;
				b = (10000 * vy + 2 * sp * vth) * k;
				w[0] = a + b;
				w[1] = b - a;
				w[2] = (-20000 * vy + 2 * sp * vth) * k;
			end
			MODE_OMNI4: begin
				w[0] = (20000 * (vx + vy) + t4) * k;
				w[1] = -(20000 * (vx - vy) - t4) * k;
				w[2] = -(20000 * (vx + vy) - t4) * k;
				w[3] = (20000 * (vx - vy) + t4) * k;
			end
			default: r.mode_error = 1'b1;
		endcase
		if (!r.mode_error) begin
			r.wheel0_speed = to_speed(w[0], reg_copy[REG_TYRE_RAD]);
			r.wheel1_speed = to_speed(w[1], reg_copy[REG_TYRE_RAD]);
			r.wheel2_speed = to_speed(w[2], reg_copy[REG_TYRE_RAD]);
			r.wheel3_speed = to_speed(w[3], reg_copy[REG_TYRE_RAD]);
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- driver
	// Valid is decided only when the slot is free; a stalled transaction is held.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd       <= '0;
			send_idle <= 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				speeds_due.push_back(wheel_speeds(cmd));
			end
			if (!cmd_valid || !cmd_stall) begin
				if (send_idle > 0) begin
					send_idle <= send_idle - 1;
					cmd_valid <= 1'b0;
				end else if (!quiet && cmd_pending.size() != 0 && $urandom_range(0, 9) == 0) begin
					send_idle <= $urandom_range(0, 5);
					cmd_valid <= 1'b0;
				end else if (cmd_pending.size() != 0) begin
					cmd       <= cmd_pending.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
			recv_idle <= 0;
			hold_cnt  <= 0;
			hold_done <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (speeds_due.size() == 0) begin
					$error("unexpected result transaction");
					err_count++;
				end else begin
					want = speeds_due.pop_front();
					if (res.wheel0_speed !== want.wheel0_speed) begin
						$error("wheel0_speed: expected %0d, got %0d", want.wheel0_speed,
						       res.wheel0_speed);
						err_count++;
					end
					if (res.wheel1_speed !== want.wheel1_speed) begin
						$error("wheel1_speed: expected %0d, got %0d", want.wheel1_speed,
						       res.wheel1_speed);
						err_count++;
					end
					if (res.wheel2_speed !== want.wheel2_speed) begin
						$error("wheel2_speed: expected %0d, got %0d", want.wheel2_speed,
						       res.wheel2_speed);
						err_count++;
					end
					if (res.wheel3_speed !== want.wheel3_speed) begin
						$error("wheel3_speed: expected %0d, got %0d", want.wheel3_speed,
						       res.wheel3_speed);
						err_count++;
					end
					if (res.mode_error !== want.mode_error) begin
						$error("mode_error: expected %0b, got %0b", want.mode_error,
						       res.mode_error);
						err_count++;
					end
				end
			end
			// long hold-off first, so the pipe fills and backs up onto cmd
			if (hold_req && !hold_done && hold_cnt == 0) begin
				hold_cnt  <= LONG_HOLD;
				hold_done <= 1'b1;
				res_stall <= 1'b1;
			end else if (hold_cnt > 1) begin
				hold_cnt <= hold_cnt - 1;
			end else if (hold_cnt == 1) begin
				hold_cnt  <= 0;
				res_stall <= 1'b0;
			end else if (recv_idle > 0) begin
				recv_idle <= recv_idle - 1;
				res_stall <= (recv_idle > 1);
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				recv_idle <= $urandom_range(1, 6);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
		    (cfg_valid && cfg_ready))
			dead_cycles <= 0;
		else
			dead_cycles <= dead_cycles + 1;
		if (dead_cycles >= STALL_LIMIT) begin
			$display("wheel_inverse_kinematics_test: done, errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequencing
	// one write, then cfg_valid low again before the task returns
	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_WHEEL_MODE: reg_copy[idx] = value & 16'h0007;
			REG_MAX_VX, REG_MAX_VY, REG_MAX_VTH: reg_copy[idx] = value & 16'h7FFF;
			default: reg_copy[idx] = value;
		endcase
	endtask

	task automatic set_all(logic [2:0] mode, logic [14:0] mx, logic [14:0] my,
	                       logic [14:0] mth, logic [15:0] rad, logic [15:0] sp,
	                       logic [15:0] bw, logic [15:0] bl);
		write_reg(REG_WHEEL_MODE, {13'd0, mode});
		write_reg(REG_MAX_VX, {1'b0, mx});
		write_reg(REG_MAX_VY, {1'b0, my});
		write_reg(REG_MAX_VTH, {1'b0, mth});
		write_reg(REG_TYRE_RAD, rad);
		write_reg(REG_WHEEL_SPACING, sp);
		write_reg(REG_BODY_WIDTH, bw);
		write_reg(REG_BODY_LENGTH, bl);
	endtask

	// sender pauses here until every predicted result is back
	task automatic drain;
		while (cmd_pending.size() != 0 || cmd_valid || speeds_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_velocity();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'(int'($urandom_range(0, 4000)) - 2000);
			3: return 16'(int'($urandom_range(0, 200)) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_size();
		case ($urandom_range(0, 4))
			0: return 16'hFFFF;
			1: return 16'd0;
			2: return 16'($urandom_range(1, 200));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [14:0] pick_limit();
		case ($urandom_range(0, 4))
			0: return 15'h7FFF;
			1: return 15'd0;
			2: return 15'($urandom_range(1, 3000));
			default: return 15'($urandom);
		endcase
	endfunction

	task automatic queue_random(int n);
		cmd_t c;
		repeat (n) begin
			c.cmd_vx  = pick_velocity();
			c.cmd_vy  = pick_velocity();
			c.cmd_vth = pick_velocity();
			cmd_pending.push_back(c);
		end
	endtask

	task automatic queue_directed;
		cmd_t c;
		logic [15:0] edges[5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
		foreach (edges[i]) begin
			c.cmd_vx = edges[i]; c.cmd_vy = edges[(i + 1) % 5]; c.cmd_vth = edges[(i + 2) % 5];
			cmd_pending.push_back(c);
		end
	endtask

	initial begin
		logic [2:0] mode;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		quiet     = 1'b0;
		hold_req  = 1'b0;
		reg_copy  = '{16'd4, 16'd1000, 16'd1000, 16'd2000, 16'd500, 16'd3000, 16'd2000, 16'd2000};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults, then each mode, widest limits, zero radius, bad modes
		queue_directed();
		drain();
		set_all(MODE_DIFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_directed();
		drain();
		write_reg(REG_WHEEL_MODE, {13'd0, MODE_OMNI3});
		queue_directed();
		drain();
		write_reg(REG_WHEEL_MODE, {13'd0, MODE_OMNI4});
		write_reg(REG_TYRE_RAD, 16'd0);
		queue_directed();
		drain();
		set_all(3'd7, 15'd0, 15'd0, 15'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
		queue_directed();
		drain();
		write_reg(REG_WHEEL_MODE, 16'd0);
		queue_directed();
		drain();

		// random settings; one phase holds the receiver off for a long stretch
		for (int p = 0; p < 10; p++) begin
			case ($urandom_range(0, 3))
				0: mode = MODE_DIFF;
				1: mode = MODE_OMNI3;
				2: mode = MODE_OMNI4;
				default: mode = 3'($urandom);
			endcase
			set_all(mode, pick_limit(), pick_limit(), pick_limit(),
			        ($urandom_range(0, 3) == 0) ? pick_size() : 16'($urandom_range(1, 2000)),
			        pick_size(), pick_size(), pick_size());
			if (p == 3) hold_req = 1'b1;
			if (p == 9) quiet = 1'b1;
			queue_random(185);
			drain();
		end

		if (err_count == 0)
			$display("wheel_inverse_kinematics_test: done, clean");
		else
			$display("wheel_inverse_kinematics_test: done, errors");
		$finish;
	end

endmodule
